// ===== rtl/alcr_pkg.sv =====
// Shared types and constants for the antialiased line column rasterizer.
// No dependencies; every other file imports this package.
package alcr_pkg;

  // Default fraction bits of the fixed-point intercept
  localparam int ALCR_FRAC_BITS = 16;

  // Coordinate field width
  localparam int COORD_W = 16;

  // Per-item fields that ride alongside the gradient divider
  typedef struct packed {
    logic signed [COORD_W-1:0] y0;        // ordered start, minor axis
    logic        [COORD_W-1:0] step;      // step index
    logic        [COORD_W-1:0] col;       // major axis pixel coordinate
    logic                      steep;     // axes swapped
    logic                      valid_res; // step within span
    logic                      last;      // step equals span
    logic                      neg;       // gradient is negative
  } alcr_side_t;

endpackage

// ===== rtl/alcr_prep.sv =====
// Front end: endpoint differences, steep test, axis swap and ordering.
// Depends on alcr_pkg.
module alcr_prep import alcr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_v,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic        [COORD_W-1:0] step_index,
  output logic                      out_v,
  output logic        [COORD_W-1:0] out_dx,
  output logic        [COORD_W-1:0] out_dym,
  output alcr_side_t                out_side
);

  // Stage 1 registers
  logic                      v1;
  logic signed [COORD_W:0]   dxr;
  logic signed [COORD_W:0]   dyr;
  logic signed [COORD_W-1:0] x0r, y0r, x1r, y1r;
  logic        [COORD_W-1:0] stepr;

  // Stage 2 combinational signals
  logic        [COORD_W:0]   adx, ady;
  logic                      steep;
  logic signed [COORD_W:0]   sdx, sdy, sdy2;
  logic signed [COORD_W-1:0] ax0, ay0, ax1, ay1, ox0, oy0;
  logic        [COORD_W-1:0] dx, dym;
  alcr_side_t                side_next;

  // Take the beat and form raw differences
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_v;
    end
    dxr   <= {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
    dyr   <= {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
    x0r   <= start_x;
    y0r   <= start_y;
    x1r   <= end_x;
    y1r   <= end_y;
    stepr <= step_index;
  end

  // Swap axes for steep lines, then order by major coordinate
  always_comb begin
    adx   = dxr[COORD_W] ? -dxr : dxr;
    ady   = dyr[COORD_W] ? -dyr : dyr;
    steep = ady > adx;
    sdx   = steep ? dyr : dxr;
    sdy   = steep ? dxr : dyr;
    ax0   = steep ? y0r : x0r;
    ay0   = steep ? x0r : y0r;
    ax1   = steep ? y1r : x1r;
    ay1   = steep ? x1r : y1r;
    ox0   = sdx[COORD_W] ? ax1 : ax0;
    oy0   = sdx[COORD_W] ? ay1 : ay0;
    dx    = sdx[COORD_W] ? COORD_W'(-sdx) : sdx[COORD_W-1:0];
    sdy2  = sdx[COORD_W] ? -sdy : sdy;
    dym   = sdy2[COORD_W] ? COORD_W'(-sdy2) : sdy2[COORD_W-1:0];
    side_next.y0        = oy0;
    side_next.step      = stepr;
    side_next.col       = ox0 + stepr;
    side_next.steep     = steep;
    side_next.valid_res = stepr <= dx;
    side_next.last      = stepr == dx;
    side_next.neg       = sdy2[COORD_W];
  end

  // Hold ordered line for the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= v1;
    end
    out_dx   <= dx;
    out_dym  <= dym;
    out_side <= side_next;
  end

endmodule

// ===== rtl/alcr_div.sv =====
// Pipelined restoring divider: gradient magnitude |dy| * 2^FRAC_BITS / dx,
// one quotient bit per stage. Depends on alcr_pkg.
module alcr_div import alcr_pkg::*; #(
  parameter int FRAC_BITS = ALCR_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_v,
  input  logic [COORD_W-1:0] in_dx,
  input  logic [COORD_W-1:0] in_dym,
  input  alcr_side_t         in_side,
  output logic               out_v,
  output logic [FRAC_BITS:0] out_q,
  output alcr_side_t         out_side
);

  localparam int QW = FRAC_BITS + 1;
  localparam int RW = COORD_W + FRAC_BITS;

  logic               v    [QW+1];
  logic [RW-1:0]      rem  [QW+1];
  logic [QW-1:0]      quo  [QW+1];
  logic [COORD_W-1:0] dxs  [QW+1];
  alcr_side_t         side [QW+1];

  // Load the dividend at the head of the chain
  assign v[0]    = in_v;
  assign rem[0]  = {in_dym, {FRAC_BITS{1'b0}}};
  assign quo[0]  = '0;
  assign dxs[0]  = in_dx;
  assign side[0] = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [RW-1:0] dsh;
    logic          ge;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] quo_next;

    // Trial subtract of the shifted divisor, keep bit if it fits
    always_comb begin
      dsh         = RW'(dxs[k]) << B;
      ge          = rem[k] >= dsh;
      rem_next    = ge ? rem[k] - dsh : rem[k];
      quo_next    = quo[k];
      quo_next[B] = ge;
    end

    // Advance one stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      rem[k+1]  <= rem_next;
      quo[k+1]  <= quo_next;
      dxs[k+1]  <= dxs[k];
      side[k+1] <= side[k];
    end
  end

  assign out_v    = v[QW];
  assign out_q    = quo[QW];
  assign out_side = side[QW];

endmodule

// ===== rtl/alcr_out.sv =====
// Back end: intercept multiply and add, floor and fraction split, opacities
// and output register. Depends on alcr_pkg.
module alcr_out import alcr_pkg::*; #(
  parameter int FRAC_BITS = ALCR_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_v,
  input  logic [FRAC_BITS:0]        in_q,
  input  alcr_side_t                in_side,
  output logic                      done,
  output logic                      valid_res,
  output logic                      last,
  output logic signed [COORD_W-1:0] upper_px,
  output logic signed [COORD_W-1:0] upper_py,
  output logic        [7:0]         upper_alpha,
  output logic signed [COORD_W-1:0] lower_px,
  output logic signed [COORD_W-1:0] lower_py,
  output logic        [7:0]         lower_alpha
);

  localparam int PW = COORD_W + FRAC_BITS + 1;
  localparam int IW = FRAC_BITS + COORD_W + 2;

  // Multiply stage
  logic              vm;
  logic [PW-1:0]     prod;
  alcr_side_t        sm;

  // Add stage
  logic              va;
  logic signed [IW-1:0] icpt;
  alcr_side_t        sa;
  logic signed [IW-1:0] yext, pext;

  // Output stage signals
  logic signed [IW-1:0]      fl;
  logic [COORD_W-1:0]        fl16, fl16p;
  logic [FRAC_BITS-1:0]      frac;
  logic [FRAC_BITS:0]        inv;
  logic [FRAC_BITS+7:0]      la_full;
  logic [FRAC_BITS+8:0]      ua_full;
  logic                      keep;

  // Step times gradient magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= in_v;
    end
    prod <= PW'(in_side.step) * PW'(in_q);
    sm   <= in_side;
  end

  // Intercept = y0 * 2^F +/- product
  assign yext = IW'(sm.y0) <<< FRAC_BITS;
  assign pext = IW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= vm;
    end
    icpt <= sm.neg ? yext - pext : yext + pext;
    sa   <= sm;
  end

  // Split floor and fraction, scale opacities by 255
  always_comb begin
    fl      = icpt >>> FRAC_BITS;
    fl16    = fl[COORD_W-1:0];
    fl16p   = fl16 + COORD_W'(1);
    frac    = icpt[FRAC_BITS-1:0];
    inv     = (FRAC_BITS+1)'(1) << FRAC_BITS;
    inv     = inv - {1'b0, frac};
    la_full = {frac, 8'd0} - {8'd0, frac};
    ua_full = {inv, 8'd0} - {8'd0, inv};
    keep    = va && sa.valid_res;
  end

  // Drive the result beat; fields are zero outside the span
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= va;
    end
    valid_res   <= keep;
    last        <= keep && sa.last;
    upper_alpha <= keep ? ua_full[FRAC_BITS+7:FRAC_BITS] : 8'd0;
    lower_alpha <= keep ? la_full[FRAC_BITS+7:FRAC_BITS] : 8'd0;
    if (!keep) begin
      upper_px <= '0;
      upper_py <= '0;
      lower_px <= '0;
      lower_py <= '0;
    end else if (sa.steep) begin
      upper_px <= fl16;
      upper_py <= sa.col;
      lower_px <= fl16p;
      lower_py <= sa.col;
    end else begin
      upper_px <= sa.col;
      upper_py <= fl16;
      lower_px <= sa.col;
      lower_py <= fl16p;
    end
  end

endmodule

// ===== rtl/antialiased_line_column_raster.sv =====
// Wu antialiased line, one column per beat. Two front-end stages,
// FRAC_BITS + 1 divider stages (one gradient bit each), then multiply,
// add and output stages. Throughput one beat per cycle; busy is high
// only during reset. Synchronous reset clears all valid bits; the result
// side never stalls. Depends on alcr_pkg, alcr_prep, alcr_div, alcr_out.
module antialiased_line_column_raster import alcr_pkg::*; #(
  parameter int FRAC_BITS = ALCR_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic        [COORD_W-1:0] step_index,
  output logic                      done,
  output logic                      valid_res,
  output logic                      last,
  output logic signed [COORD_W-1:0] upper_px,
  output logic signed [COORD_W-1:0] upper_py,
  output logic        [7:0]         upper_alpha,
  output logic signed [COORD_W-1:0] lower_px,
  output logic signed [COORD_W-1:0] lower_py,
  output logic        [7:0]         lower_alpha
);

  logic               accept;
  logic               pv;
  logic [COORD_W-1:0] pdx, pdym;
  alcr_side_t         pside;
  logic               dv;
  logic [FRAC_BITS:0] dq;
  alcr_side_t         dside;

  // Take a beat whenever not in reset
  assign busy   = rst;
  assign accept = start && !busy;

  alcr_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_v       (accept),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .step_index (step_index),
    .out_v      (pv),
    .out_dx     (pdx),
    .out_dym    (pdym),
    .out_side   (pside)
  );

  alcr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_v     (pv),
    .in_dx    (pdx),
    .in_dym   (pdym),
    .in_side  (pside),
    .out_v    (dv),
    .out_q    (dq),
    .out_side (dside)
  );

  alcr_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk         (clk),
    .rst         (rst),
    .in_v        (dv),
    .in_q        (dq),
    .in_side     (dside),
    .done        (done),
    .valid_res   (valid_res),
    .last        (last),
    .upper_px    (upper_px),
    .upper_py    (upper_py),
    .upper_alpha (upper_alpha),
    .lower_px    (lower_px),
    .lower_py    (lower_py),
    .lower_alpha (lower_alpha)
  );

endmodule

// ===== rtl/alcr_checker.sv =====
// Port-level checks for the antialiased line column rasterizer, bound to
// the top level. Depends on alcr_pkg.
module alcr_checker import alcr_pkg::*; #(
  parameter int FRAC_BITS = ALCR_FRAC_BITS
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic                      valid_res,
  input logic                      last,
  input logic signed [COORD_W-1:0] upper_px,
  input logic signed [COORD_W-1:0] upper_py,
  input logic        [7:0]         upper_alpha,
  input logic signed [COORD_W-1:0] lower_px,
  input logic signed [COORD_W-1:0] lower_py,
  input logic        [7:0]         lower_alpha
);

  localparam int LAT = FRAC_BITS + 6;

  // Every accepted beat comes out as a done strobe, and no other done appears
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, LAT))
    else $error("result strobe does not match accepted beat");

  // Last column only inside the span
  a_last: assert property (@(posedge clk) disable iff (rst)
    last |-> valid_res && done)
    else $error("last without valid result");

  // Two opacities split 255 up to one lost by truncation
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    valid_res |-> ((9'(upper_alpha) + 9'(lower_alpha)) == 9'd255 ||
                   (9'(upper_alpha) + 9'(lower_alpha)) == 9'd254))
    else $error("opacities do not sum to full scale");

  // Lower pixel sits one beyond the upper on the minor axis
  a_pair: assert property (@(posedge clk) disable iff (rst)
    valid_res |-> ((upper_px == lower_px && lower_py == upper_py + 16'sd1) ||
                   (upper_py == lower_py && lower_px == upper_px + 16'sd1)))
    else $error("pixel pair not adjacent");

endmodule

bind antialiased_line_column_raster alcr_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (.*);
